// ===== sv/mmn_pkg.sv =====
// ----------------------------------------------------------------------------
// mmn_pkg
// Shared types, sizes and decode helpers of the memory map normalizer.
// ----------------------------------------------------------------------------
package mmn_pkg;

  localparam int STORE_DEPTH = 512;
  localparam int MEM_OUT_MAX = 32;
  localparam int RT_OUT_MAX  = 32;

  // count holds 0..STORE_DEPTH, index 0..STORE_DEPTH-1, address spans both lists
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int IDX_W  = $clog2(STORE_DEPTH);
  localparam int ADDR_W = $clog2(2 * STORE_DEPTH);

  localparam int PAGE_SHIFT = 12;
  localparam int ATTR_WB    = 3;
  localparam int ATTR_RT    = 63;

  // region classes
  localparam logic [2:0] CLS_RAM     = 3'd0;
  localparam logic [2:0] CLS_RSVD    = 3'd1;
  localparam logic [2:0] CLS_RECLAIM = 3'd2;
  localparam logic [2:0] CLS_NVS     = 3'd3;
  localparam logic [2:0] CLS_UNUSE   = 3'd4;

  // firmware memory type codes
  localparam logic [3:0] KIND_LDR_CODE  = 4'd1;
  localparam logic [3:0] KIND_LDR_DATA  = 4'd2;
  localparam logic [3:0] KIND_BS_CODE   = 4'd3;
  localparam logic [3:0] KIND_BS_DATA   = 4'd4;
  localparam logic [3:0] KIND_RT_CODE   = 4'd5;
  localparam logic [3:0] KIND_RT_DATA   = 4'd6;
  localparam logic [3:0] KIND_CONV      = 4'd7;
  localparam logic [3:0] KIND_UNUSABLE  = 4'd8;
  localparam logic [3:0] KIND_ACPI_RECL = 4'd9;
  localparam logic [3:0] KIND_ACPI_NVS  = 4'd10;

  // one stored range; size is bytes for memory entries, pages for runtime ones
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] size;
    logic [63:0] attr;
    logic [3:0]  kind;
    logic [2:0]  cls;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  typedef struct packed {
    logic              clear;
    logic              start;
    logic              advance;
    logic              in_valid;
    logic              eligible;
    logic [63:0]       key;
    logic [IDX_W-1:0]  idx;
  } scan_ctl_t;

  typedef struct packed {
    logic              found;
    logic [63:0]       best_key;
    logic [IDX_W-1:0]  best_idx;
    logic              have_thr;
    logic [63:0]       thr_key;
    logic [IDX_W-1:0]  thr_idx;
  } scan_st_t;

  function automatic logic [2:0] class_of(input logic [3:0] kind, input logic [63:0] attr);
    logic [2:0] c;
    unique case (kind)
      KIND_LDR_CODE, KIND_LDR_DATA, KIND_BS_CODE, KIND_BS_DATA, KIND_CONV:
        c = attr[ATTR_WB] ? CLS_RAM : CLS_RSVD;
      KIND_ACPI_RECL: c = CLS_RECLAIM;
      KIND_ACPI_NVS:  c = CLS_NVS;
      KIND_UNUSABLE:  c = CLS_UNUSE;
      default:        c = CLS_RSVD;
    endcase
    return c;
  endfunction

  function automatic logic wants_rt(input logic [3:0] kind, input logic [63:0] attr);
    return attr[ATTR_RT] || kind == KIND_BS_CODE || kind == KIND_BS_DATA ||
           kind == KIND_RT_CODE || kind == KIND_RT_DATA || kind == KIND_ACPI_NVS;
  endfunction

endpackage

// ===== sv/mmn_desc_if.sv =====
// ----------------------------------------------------------------------------
// mmn_desc_if
// Descriptor channel: one firmware memory descriptor per item.
// ----------------------------------------------------------------------------
interface mmn_desc_if;
  logic        valid;
  logic        ready;
  logic [63:0] region_base;
  logic [51:0] page_count;
  logic [63:0] attribute_bits;
  logic [3:0]  firmware_kind;
  logic        final_descriptor;

  modport source (output valid, region_base, page_count, attribute_bits, firmware_kind,
                  final_descriptor, input ready);
  modport sink   (input valid, region_base, page_count, attribute_bits, firmware_kind,
                  final_descriptor, output ready);
endinterface

// ===== sv/mmn_range_if.sv =====
// ----------------------------------------------------------------------------
// mmn_range_if
// Result channel: one normalized memory or runtime range per item.
// ----------------------------------------------------------------------------
interface mmn_range_if;
  logic        valid;
  logic        ready;
  logic        list_kind;
  logic [63:0] range_start;
  logic [63:0] range_size;
  logic [2:0]  region_class;
  logic [3:0]  runtime_kind;
  logic [63:0] runtime_attributes;
  logic        end_of_output;

  modport source (output valid, list_kind, range_start, range_size, region_class,
                  runtime_kind, runtime_attributes, end_of_output, input ready);
  modport sink   (input valid, list_kind, range_start, range_size, region_class,
                  runtime_kind, runtime_attributes, end_of_output, output ready);
endinterface

// ===== sv/mmn_ram.sv =====
// ----------------------------------------------------------------------------
// mmn_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmn_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/mmn_scan.sv =====
// ----------------------------------------------------------------------------
// mmn_scan
// Shared minimum finder: over one pass, keep the smallest (key, index) among
// eligible entries that lies strictly above the current threshold.
// ----------------------------------------------------------------------------
module mmn_scan (
  input  logic              clk,
  input  logic              rst,
  input  mmn_pkg::scan_ctl_t ctl,
  output mmn_pkg::scan_st_t  st
);

  logic                        found;
  logic [63:0]                 best_key;
  logic [mmn_pkg::IDX_W-1:0]   best_idx;
  logic                        have_thr;
  logic [63:0]                 thr_key;
  logic [mmn_pkg::IDX_W-1:0]   thr_idx;
  logic                        above;
  logic                        take;

  // entries arrive in rising index order, so a strict key compare keeps the earliest
  assign above = !have_thr || (ctl.key > thr_key) ||
                 (ctl.key == thr_key && ctl.idx > thr_idx);
  assign take  = ctl.in_valid && ctl.eligible && above && (!found || ctl.key < best_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      found    <= 1'b0;
      have_thr <= 1'b0;
    end else if (ctl.clear) begin
      found    <= 1'b0;
      have_thr <= 1'b0;
    end else if (ctl.advance) begin
      found    <= 1'b0;
      have_thr <= 1'b1;
      thr_key  <= best_key;
      thr_idx  <= best_idx;
    end else if (ctl.start) begin
      found <= 1'b0;
    end else if (take) begin
      found    <= 1'b1;
      best_key <= ctl.key;
      best_idx <= ctl.idx;
    end
  end

  assign st = '{found: found, best_key: best_key, best_idx: best_idx,
                have_thr: have_thr, thr_key: thr_key, thr_idx: thr_idx};

  a_adv_thr: assert property (@(posedge clk) disable iff (rst)
    ctl.advance && !ctl.clear |=> have_thr) else $error("threshold not set on advance");
  a_start_clr: assert property (@(posedge clk) disable iff (rst)
    ctl.start |=> !found) else $error("pass start left a winner");
  a_best_above: assert property (@(posedge clk) disable iff (rst)
    found && have_thr |-> (best_key > thr_key || (best_key == thr_key && best_idx > thr_idx)))
    else $error("winner not above threshold");

endmodule

// ===== sv/memory_map_normalizer_core.sv =====
// ----------------------------------------------------------------------------
// memory_map_normalizer_core
// Collects firmware memory descriptors, then sorts, merges, trims and emits
// a normalized memory map followed by a runtime-services map.
// ----------------------------------------------------------------------------
// Descriptors are taken one per cycle while the block is idle; a descriptor
// that is also copied to the runtime list holds off the next one for the
// second store write. After the final descriptor the block is busy: each list
// of n stored entries is sorted by n selection passes of the shared minimum
// finder, each pass reading every stored entry, one store read per cycle, and
// then fetching the winner and merging it. When the merged memory list holds
// k > MEM_OUT_MAX ranges, the trim takes up to k - MEM_OUT_MAX further passes
// over it. Every range is then read and checked; an emitted range is held for
// the sink, and a dropped range is skipped. The single read port of the store
// and the one shared compare unit set this pace. A map whose lists are both
// empty ends without any item on the result channel.
// ----------------------------------------------------------------------------
module memory_map_normalizer_core (
  input  logic          clk,
  input  logic          rst,
  mmn_desc_if.sink      desc,
  mmn_range_if.source   ranges
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RTWR   = 4'd1;
  localparam logic [3:0] S_START  = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_FETCH  = 4'd4;
  localparam logic [3:0] S_MERGE  = 4'd5;
  localparam logic [3:0] S_FLUSH  = 4'd6;
  localparam logic [3:0] S_TSTEP  = 4'd7;
  localparam logic [3:0] S_OBEGIN = 4'd8;
  localparam logic [3:0] S_ORD    = 4'd9;
  localparam logic [3:0] S_OCHK   = 4'd10;
  localparam logic [3:0] S_OHOLD  = 4'd11;

  localparam int CW = mmn_pkg::CNT_W;
  localparam int IW = mmn_pkg::IDX_W;
  localparam int AW = mmn_pkg::ADDR_W;

  logic [3:0]    state;
  logic          lst;       // 0 memory list, 1 runtime list
  logic          trim;      // scan runs over merged memory list for the trim
  logic [CW-1:0] mem_n, rt_n, mem_k, rt_k;
  logic [CW-1:0] rd_i, sel, k, r, rs, oi;
  logic [CW:0]   ecnt;
  logic          last_q;
  logic          rvalid;
  logic [IW-1:0] ridx;
  mmn_pkg::ent_t acc, rt_ent;
  logic [63:0]   acc_end;
  logic          acc_v;

  mmn_pkg::ent_t raw_wdata, raw_rdata, mrg_rdata, in_ent;
  logic          raw_we, mrg_we;
  logic [AW-1:0] raw_waddr, raw_raddr, mrg_waddr, mrg_raddr;

  mmn_pkg::scan_ctl_t sctl;
  mmn_pkg::scan_st_t  sst;

  // --- descriptor decode ---------------------------------------------------
  logic accept, store_ok, rt_take;
  assign accept   = desc.valid && desc.ready;
  assign store_ok = (mem_n < CW'(mmn_pkg::STORE_DEPTH)) && (desc.page_count != '0);
  assign rt_take  = store_ok && mmn_pkg::wants_rt(desc.firmware_kind, desc.attribute_bits) &&
                    (desc.region_base[mmn_pkg::PAGE_SHIFT-1:0] == '0);

  always_comb begin
    in_ent      = '0;
    in_ent.base = desc.region_base;
    in_ent.size = {desc.page_count, {mmn_pkg::PAGE_SHIFT{1'b0}}};
    in_ent.cls  = mmn_pkg::class_of(desc.firmware_kind, desc.attribute_bits);
  end

  assign desc.ready = (state == S_IDLE);

  // --- list bookkeeping ----------------------------------------------------
  logic [CW-1:0] ncur, trim_m, list_len;
  logic          rt_ok, list_last;
  logic [CW:0]   total;

  assign ncur     = trim ? mem_k : (lst ? rt_n : mem_n);
  assign trim_m   = (mem_k > CW'(mmn_pkg::MEM_OUT_MAX)) ?
                    mem_k - CW'(mmn_pkg::MEM_OUT_MAX) : '0;
  assign rt_ok    = (rt_k <= CW'(mmn_pkg::RT_OUT_MAX));
  assign total    = {1'b0, mem_k - trim_m} + (rt_ok ? {1'b0, rt_k} : '0);
  assign list_len = lst ? rt_k : mem_k;
  assign list_last = (oi + 1'b1 == list_len);

  function automatic logic [AW-1:0] addr_of(input logic l, input logic [IW-1:0] i);
    return l ? (AW'(i) + AW'(mmn_pkg::STORE_DEPTH)) : AW'(i);
  endfunction

  // --- store ports ---------------------------------------------------------
  assign raw_we    = (state == S_IDLE && accept && store_ok) || (state == S_RTWR);
  assign raw_waddr = (state == S_RTWR) ? addr_of(1'b1, rt_n[IW-1:0]) :
                                         addr_of(1'b0, mem_n[IW-1:0]);
  assign raw_wdata = (state == S_RTWR) ? rt_ent : in_ent;
  assign raw_raddr = (state == S_FETCH) ? addr_of(lst, sst.best_idx) :
                                          addr_of(lst, rd_i[IW-1:0]);

  // --- merge decision ------------------------------------------------------
  logic        match;
  logic [63:0] e_bytes, end_sum;
  assign match   = acc_v && (acc_end == raw_rdata.base) &&
                   (lst ? (acc.attr == raw_rdata.attr) : (acc.cls == raw_rdata.cls));
  assign e_bytes = lst ? {raw_rdata.size[63-mmn_pkg::PAGE_SHIFT:0],
                          {mmn_pkg::PAGE_SHIFT{1'b0}}} : raw_rdata.size;
  // one adder: extend the running end, or open a new range end
  assign end_sum = (match ? acc_end : raw_rdata.base) + e_bytes;

  assign mrg_we    = ((state == S_MERGE) && acc_v && !match) || ((state == S_FLUSH) && acc_v);
  assign mrg_waddr = addr_of(lst, k[IW-1:0]);
  assign mrg_raddr = (state == S_SCAN) ? addr_of(1'b0, rd_i[IW-1:0]) :
                                         addr_of(lst, oi[IW-1:0]);

  mmn_ram #(.W(mmn_pkg::ENT_W), .D(2 * mmn_pkg::STORE_DEPTH)) u_raw (
    .clk(clk), .we(raw_we), .waddr(raw_waddr), .wdata(raw_wdata),
    .raddr(raw_raddr), .rdata(raw_rdata)
  );

  mmn_ram #(.W(mmn_pkg::ENT_W), .D(2 * mmn_pkg::STORE_DEPTH)) u_mrg (
    .clk(clk), .we(mrg_we), .waddr(mrg_waddr), .wdata(acc),
    .raddr(mrg_raddr), .rdata(mrg_rdata)
  );

  // --- shared minimum finder ------------------------------------------------
  logic start_list, start_trim, pass_ok;
  assign start_list = (state == S_START) || (state == S_FLUSH && !lst);
  assign start_trim = (state == S_FLUSH) && lst && (trim_m != '0);
  assign pass_ok    = (state == S_TSTEP) && sst.found;

  always_comb begin
    sctl          = '0;
    sctl.clear    = start_list || start_trim;
    sctl.start    = (state == S_SCAN) && (rd_i == '0);
    sctl.advance  = (state == S_MERGE) || pass_ok;
    sctl.in_valid = rvalid;
    sctl.idx      = ridx;
    // sort orders by base, trim removes the smallest non-RAM range first
    sctl.key      = trim ? mrg_rdata.size : raw_rdata.base;
    sctl.eligible = trim ? (mrg_rdata.cls != mmn_pkg::CLS_RAM) : 1'b1;
  end

  mmn_scan u_scan (.clk(clk), .rst(rst), .ctl(sctl), .st(sst));

  // --- trim filter on output -----------------------------------------------
  logic drop;
  always_comb begin
    drop = 1'b0;
    if (!lst) begin
      if (mrg_rdata.cls != mmn_pkg::CLS_RAM) begin
        drop = (r != '0) && ((mrg_rdata.size < sst.thr_key) ||
               (mrg_rdata.size == sst.thr_key && oi[IW-1:0] <= sst.thr_idx));
      end else begin
        // non-RAM ranges ran out: drop leading RAM ranges for the rest
        drop = (rs < trim_m - r);
      end
    end
  end

  // --- output register -----------------------------------------------------
  logic        o_kind, o_eoo;
  logic [63:0] o_start, o_size, o_attr;
  logic [2:0]  o_cls;
  logic [3:0]  o_rkind;

  assign ranges.valid              = (state == S_OHOLD);
  assign ranges.list_kind          = o_kind;
  assign ranges.range_start        = o_start;
  assign ranges.range_size         = o_size;
  assign ranges.region_class       = o_cls;
  assign ranges.runtime_kind       = o_rkind;
  assign ranges.runtime_attributes = o_attr;
  assign ranges.end_of_output      = o_eoo;

  // --- sequencer -----------------------------------------------------------
  logic step, finish;
  assign step   = ((state == S_OCHK) && drop) || ((state == S_OHOLD) && ranges.ready);
  assign finish = (step && list_last && (lst || !rt_ok || rt_k == '0)) ||
                  ((state == S_OBEGIN) && mem_k == '0 && !(rt_ok && rt_k != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      mem_n  <= '0;
      rt_n   <= '0;
      rvalid <= 1'b0;
      acc_v  <= 1'b0;
      lst    <= 1'b0;
      trim   <= 1'b0;
    end else begin
      rvalid <= (state == S_SCAN) && (rd_i < ncur);
      ridx   <= rd_i[IW-1:0];
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            last_q <= desc.final_descriptor;
            rt_ent <= '{base: desc.region_base, size: 64'(desc.page_count),
                        attr: desc.attribute_bits, kind: desc.firmware_kind,
                        cls: mmn_pkg::CLS_RAM};
            if (store_ok) begin
              mem_n <= mem_n + 1'b1;
            end
            if (rt_take) begin
              state <= S_RTWR;
            end else if (desc.final_descriptor) begin
              state <= S_START;
            end
          end
        end
        S_RTWR: begin
          rt_n  <= rt_n + 1'b1;
          state <= last_q ? S_START : S_IDLE;
        end
        S_START: begin
          lst   <= 1'b0;
          trim  <= 1'b0;
          sel   <= '0;
          k     <= '0;
          rd_i  <= '0;
          acc_v <= 1'b0;
          state <= (mem_n == '0) ? S_FLUSH : S_SCAN;
        end
        S_SCAN: begin
          if (rd_i == ncur) begin
            state <= trim ? S_TSTEP : S_FETCH;
          end else begin
            rd_i <= rd_i + 1'b1;
          end
        end
        S_FETCH: begin
          state <= S_MERGE;
        end
        S_MERGE: begin
          acc_end <= end_sum;
          if (match) begin
            acc.size <= acc.size + raw_rdata.size;
          end else begin
            acc   <= raw_rdata;
            acc_v <= 1'b1;
            if (acc_v) begin
              k <= k + 1'b1;
            end
          end
          sel  <= sel + 1'b1;
          rd_i <= '0;
          state <= (sel + 1'b1 == ncur) ? S_FLUSH : S_SCAN;
        end
        S_FLUSH: begin
          acc_v <= 1'b0;
          k     <= '0;
          sel   <= '0;
          rd_i  <= '0;
          if (!lst) begin
            mem_k <= k + CW'(acc_v);
            lst   <= 1'b1;
            // stay here on an empty runtime list
            state <= (rt_n == '0) ? S_FLUSH : S_SCAN;
          end else begin
            rt_k <= k + CW'(acc_v);
            r    <= '0;
            if (start_trim) begin
              trim  <= 1'b1;
              state <= S_SCAN;
            end else begin
              state <= S_OBEGIN;
            end
          end
        end
        S_TSTEP: begin
          rd_i <= '0;
          if (sst.found) begin
            r     <= r + 1'b1;
            state <= (r + 1'b1 == trim_m) ? S_OBEGIN : S_SCAN;
          end else begin
            state <= S_OBEGIN;
          end
        end
        S_OBEGIN: begin
          trim <= 1'b0;
          oi   <= '0;
          rs   <= '0;
          ecnt <= '0;
          // an empty map leaves through the finish path below
          if (!finish) begin
            lst   <= (mem_k == '0);
            state <= S_ORD;
          end
        end
        S_ORD: begin
          state <= S_OCHK;
        end
        S_OCHK: begin
          if (drop) begin
            if (mrg_rdata.cls == mmn_pkg::CLS_RAM) begin
              rs <= rs + 1'b1;
            end
          end else begin
            o_kind  <= lst;
            o_start <= mrg_rdata.base;
            o_size  <= mrg_rdata.size;
            o_cls   <= lst ? mmn_pkg::CLS_RAM : mrg_rdata.cls;
            o_rkind <= lst ? mrg_rdata.kind : '0;
            o_attr  <= lst ? mrg_rdata.attr : '0;
            o_eoo   <= (ecnt + 1'b1 == total);
            state   <= S_OHOLD;
          end
        end
        S_OHOLD: begin
          if (ranges.ready) begin
            ecnt <= ecnt + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // advance through the lists, memory first
      if (step && !finish) begin
        state <= S_ORD;
        if (list_last) begin
          lst <= 1'b1;
          oi  <= '0;
        end else begin
          oi <= oi + 1'b1;
        end
      end
      if (finish) begin
        state <= S_IDLE;
        mem_n <= '0;
        rt_n  <= '0;
        lst   <= 1'b0;
      end
    end
  end

  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    ranges.valid |-> !desc.ready) else $error("descriptor taken while emitting");
  a_rt_count: assert property (@(posedge clk) disable iff (rst)
    rt_n <= mem_n) else $error("runtime list longer than memory list");
  a_mem_fields: assert property (@(posedge clk) disable iff (rst)
    ranges.valid && !ranges.list_kind |-> ranges.runtime_attributes == '0 &&
    ranges.runtime_kind == '0) else $error("memory range carries runtime fields");

endmodule
